FILE: design/sbm_pkg.sv
package sbm_pkg;

    // request kinds
    localparam logic [1:0] FN_WRITE = 2'd0;
    localparam logic [1:0] FN_EXEC  = 2'd1;
    localparam logic [1:0] FN_INIT  = 2'd2;

    // error codes
    localparam logic [2:0] ERR_NONE  = 3'd0;
    localparam logic [2:0] ERR_HALT  = 3'd1;
    localparam logic [2:0] ERR_OVFL  = 3'd2;
    localparam logic [2:0] ERR_UNFL  = 3'd3;
    localparam logic [2:0] ERR_DIVZ  = 3'd4;
    localparam logic [2:0] ERR_MEM   = 3'd5;
    localparam logic [2:0] ERR_REG   = 3'd6;
    localparam logic [2:0] ERR_BADOP = 3'd7;

    // opcodes
    localparam logic [7:0] OP_HALT = 8'h00;
    localparam logic [7:0] OP_PUSH = 8'h01;
    localparam logic [7:0] OP_POP  = 8'h02;
    localparam logic [7:0] OP_ADD  = 8'h03;
    localparam logic [7:0] OP_SUB  = 8'h04;
    localparam logic [7:0] OP_MUL  = 8'h05;
    localparam logic [7:0] OP_DIV  = 8'h06;
    localparam logic [7:0] OP_AND  = 8'h07;
    localparam logic [7:0] OP_OR   = 8'h08;
    localparam logic [7:0] OP_XOR  = 8'h09;
    localparam logic [7:0] OP_NOT  = 8'h0A;
    localparam logic [7:0] OP_JMP  = 8'h0B;
    localparam logic [7:0] OP_JZ   = 8'h0C;
    localparam logic [7:0] OP_JNZ  = 8'h0D;
    localparam logic [7:0] OP_EQ   = 8'h0E;
    localparam logic [7:0] OP_NEQ  = 8'h0F;
    localparam logic [7:0] OP_GT   = 8'h10;
    localparam logic [7:0] OP_LT   = 8'h11;
    localparam logic [7:0] OP_LDB  = 8'h12;
    localparam logic [7:0] OP_STB  = 8'h13;
    localparam logic [7:0] OP_LDR  = 8'h14;
    localparam logic [7:0] OP_STR  = 8'h15;
    localparam logic [7:0] OP_PRD  = 8'h16;
    localparam logic [7:0] OP_PRC  = 8'h17;
    localparam logic [7:0] OP_IN   = 8'h18;
    localparam logic [7:0] OP_ROL  = 8'h19;
    localparam logic [7:0] OP_ROR  = 8'h1A;
    localparam logic [7:0] OP_SWAP = 8'h1B;
    localparam logic [7:0] OP_DUP  = 8'h1C;

    typedef struct packed {
        logic       has_opnd;
        logic [1:0] n_pops;
        logic       rd_reg;
        logic       rd_mem;
        logic       is_div;
    } t_dec;

    typedef struct packed {
        logic accept;
        logic hwr;
        logic init;
        logic clr_step;
        logic fetch;
        logic latch_op;
        logic latch_opnd;
        logic pop_req;
        logic pop_cap;
        logic pop_to_a;
        logic reg_rd;
        logic mem_rd;
        logic exec;
        logic div_step;
        logic push;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic [1:0] func;
        logic       run;
        logic [7:0] opcode;
        logic       div_busy;
        logic       push_pend;
        logic       clr_last;
        logic       out_free;
    } t_sts;

    function automatic t_dec sbm_decode(input logic [7:0] op);
        t_dec d;
        d = '0;
        case (op)
            OP_PUSH, OP_JMP, OP_JZ, OP_JNZ: d.has_opnd = 1'b1;
            OP_POP, OP_NOT, OP_PRD, OP_PRC, OP_DUP: d.n_pops = 2'd1;
            OP_ADD, OP_SUB, OP_MUL, OP_AND, OP_OR, OP_XOR,
            OP_EQ, OP_NEQ, OP_GT, OP_LT, OP_STB,
            OP_ROL, OP_ROR, OP_SWAP: d.n_pops = 2'd2;
            OP_DIV: begin
                d.n_pops = 2'd2;
                d.is_div = 1'b1;
            end
            OP_LDB: begin
                d.n_pops = 2'd1;
                d.rd_mem = 1'b1;
            end
            OP_LDR: begin
                d.has_opnd = 1'b1;
                d.rd_reg   = 1'b1;
            end
            OP_STR: begin
                d.has_opnd = 1'b1;
                d.n_pops   = 2'd1;
            end
            default: d = '0;
        endcase
        return d;
    endfunction

endpackage

FILE: design/stack_bytecode_machine_top.sv
// Byte-coded stack machine. Each request either writes one program byte,
// executes one instruction at the program counter, or reinitializes the
// machine; each request yields exactly one result carrying the run flag,
// the next program counter, any printed value, input consumption and the
// first error raised. The block works on one request at a time; a finished
// result waits in an output register, so a new request can be taken while it
// is still pending. The time an instruction takes depends on operand fetch,
// up to two pops (each through the registered stack memory read) and up to
// two pushes. A division runs the bit-serial restoring divider for 32
// steps and then hands off the quotient; a division by zero skips the
// divider. After reset, and on every reinitialize request, a clearing pass
// zeroes program memory one byte per cycle, during which no request is
// taken.
module stack_bytecode_machine_top import sbm_pkg::*; #(
    parameter int MEM_BYTES   = 1024,
    parameter int STACK_DEPTH = 256,
    parameter int NUM_REGS    = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [1:0]         i_func,
    input  logic [9:0]         i_address,
    input  logic [7:0]         i_data_byte,
    input  logic signed [8:0]  i_input_char,
    output logic               o_valid,
    input  logic               i_ready,
    output logic               o_running,
    output logic [9:0]         o_next_pc,
    output logic               o_print_valid,
    output logic               o_print_is_char,
    output logic signed [31:0] o_print_value,
    output logic               o_input_used,
    output logic [2:0]         o_error_code
);

    t_cmd cmd;  // sequencer commands to the datapath
    t_sts sts;  // datapath status back to the sequencer

    sbm_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    // memories, stack pointer, program counter, ALU and divider
    sbm_datapath #(
        .MEM_BYTES   (MEM_BYTES),
        .STACK_DEPTH (STACK_DEPTH),
        .NUM_REGS    (NUM_REGS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_func          (i_func),
        .i_address       (i_address),
        .i_data_byte     (i_data_byte),
        .i_input_char    (i_input_char),
        .i_ready         (i_ready),
        .o_valid         (o_valid),
        .o_running       (o_running),
        .o_next_pc       (o_next_pc),
        .o_print_valid   (o_print_valid),
        .o_print_is_char (o_print_is_char),
        .o_print_value   (o_print_value),
        .o_input_used    (o_input_used),
        .o_error_code    (o_error_code)
    );

endmodule

FILE: design/sbm_ctrl.sv
module sbm_ctrl import sbm_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [4:0] {
        S_CLR, S_IDLE, S_DISP, S_HWR, S_INIT, S_FETCH, S_OPC, S_DEC, S_OPNDL,
        S_POP1, S_POP1W, S_POP2, S_POP2W, S_REG, S_MRD, S_EXEC, S_DIV,
        S_PUSH, S_DONE
    } t_state;

    t_state r_state;
    logic   r_init_item;
    t_dec   dec;
    t_state after_pops;
    t_state after_opnd;

    assign dec = sbm_decode(i_sts.opcode);

    always_comb begin
        if (dec.rd_reg) begin
            after_pops = S_REG;
        end else if (dec.rd_mem) begin
            after_pops = S_MRD;
        end else begin
            after_pops = S_EXEC;
        end
        after_opnd = (dec.n_pops != 2'd0) ? S_POP1 : after_pops;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_init_item <= 1'b0;
        end else begin
            case (r_state)
                S_CLR: begin
                    if (i_sts.clr_last) begin
                        r_state     <= r_init_item ? S_DONE : S_IDLE;
                        r_init_item <= 1'b0;
                    end
                end
                S_IDLE: if (i_valid) r_state <= S_DISP;
                S_DISP: begin
                    case (i_sts.func)
                        FN_WRITE: r_state <= S_HWR;
                        FN_INIT:  r_state <= S_INIT;
                        FN_EXEC:  r_state <= i_sts.run ? S_FETCH : S_DONE;
                        default:  r_state <= S_DONE;
                    endcase
                end
                S_HWR: r_state <= S_DONE;
                S_INIT: begin
                    r_state     <= S_CLR;
                    r_init_item <= 1'b1;
                end
                S_FETCH: r_state <= S_OPC;
                S_OPC:   r_state <= S_DEC;
                S_DEC:   r_state <= dec.has_opnd ? S_OPNDL : after_opnd;
                S_OPNDL: r_state <= after_opnd;
                S_POP1:  r_state <= S_POP1W;
                S_POP1W: r_state <= (dec.n_pops == 2'd2) ? S_POP2 : after_pops;
                S_POP2:  r_state <= S_POP2W;
                S_POP2W: r_state <= after_pops;
                S_REG:   r_state <= S_EXEC;
                S_MRD:   r_state <= S_EXEC;
                S_EXEC:  r_state <= dec.is_div ? S_DIV : S_PUSH;
                S_DIV:   if (!i_sts.div_busy) r_state <= S_PUSH;
                S_PUSH:  if (!i_sts.push_pend) r_state <= S_DONE;
                S_DONE:  if (i_sts.out_free) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_ready = (r_state == S_IDLE);

    always_comb begin
        o_cmd            = '0;
        o_cmd.accept     = (r_state == S_IDLE) && i_valid;
        o_cmd.hwr        = (r_state == S_HWR);
        o_cmd.init       = (r_state == S_INIT);
        o_cmd.clr_step   = (r_state == S_CLR);
        o_cmd.fetch      = (r_state == S_FETCH) || ((r_state == S_DEC) && dec.has_opnd);
        o_cmd.latch_op   = (r_state == S_OPC);
        o_cmd.latch_opnd = (r_state == S_OPNDL);
        o_cmd.pop_req    = (r_state == S_POP1) || (r_state == S_POP2);
        o_cmd.pop_cap    = (r_state == S_POP1W) || (r_state == S_POP2W);
        o_cmd.pop_to_a   = (r_state == S_POP2W);
        o_cmd.reg_rd     = (r_state == S_REG);
        o_cmd.mem_rd     = (r_state == S_MRD);
        o_cmd.exec       = (r_state == S_EXEC);
        o_cmd.div_step   = (r_state == S_DIV) && i_sts.div_busy;
        o_cmd.push       = (r_state == S_PUSH) && i_sts.push_pend;
        o_cmd.out_load   = (r_state == S_DONE) && i_sts.out_free;
    end

endmodule

FILE: design/sbm_datapath.sv
module sbm_datapath import sbm_pkg::*; #(
    parameter int MEM_BYTES   = 1024,
    parameter int STACK_DEPTH = 256,
    parameter int NUM_REGS    = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    output t_sts               o_sts,
    input  logic [1:0]         i_func,
    input  logic [9:0]         i_address,
    input  logic [7:0]         i_data_byte,
    input  logic signed [8:0]  i_input_char,
    input  logic               i_ready,
    output logic               o_valid,
    output logic               o_running,
    output logic [9:0]         o_next_pc,
    output logic               o_print_valid,
    output logic               o_print_is_char,
    output logic signed [31:0] o_print_value,
    output logic               o_input_used,
    output logic [2:0]         o_error_code
);

    localparam int PW  = $clog2(MEM_BYTES);
    localparam int SW  = $clog2(STACK_DEPTH);
    localparam int SPW = $clog2(STACK_DEPTH + 1);
    localparam int RW  = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;

    // storage
    logic [7:0]  r_mem [MEM_BYTES];
    logic [7:0]  r_mem_q;
    logic [31:0] r_stk [STACK_DEPTH];
    logic [31:0] r_stk_q;
    logic [31:0] r_regs [NUM_REGS];
    logic [31:0] r_reg_q;
    logic        r_reg_vq;

    // control state
    logic [PW-1:0]       r_pc;
    logic [SPW-1:0]      r_sp;
    logic                r_run;
    logic                r_cmp;
    logic [NUM_REGS-1:0] r_reg_vld;
    logic [PW-1:0]       r_clr_addr;
    logic [2:0]          r_err;
    logic [1:0]          r_push_cnt;
    logic                r_div_busy;
    logic [4:0]          r_div_cnt;
    logic                r_o_valid;

    // payload
    logic [1:0]  r_func;
    logic [9:0]  r_addr;
    logic [7:0]  r_data;
    logic [8:0]  r_ichr;
    logic [7:0]  r_op;
    logic [7:0]  r_opnd;
    logic [31:0] r_a;
    logic [31:0] r_b;
    logic        r_pop_zero;
    logic        r_pv;
    logic        r_pic;
    logic [31:0] r_pval;
    logic        r_iused;
    logic [31:0] r_push0;
    logic [31:0] r_push1;
    logic [31:0] r_rem;
    logic [31:0] r_quo;
    logic [31:0] r_dvs;
    logic        r_div_neg;
    logic        r_o_running;
    logic [9:0]  r_o_pc;
    logic        r_o_pv;
    logic        r_o_pic;
    logic [31:0] r_o_pval;
    logic        r_o_iused;
    logic [2:0]  r_o_err;

    // combinational
    logic [PW-1:0]  pc_inc;
    logic [SPW-1:0] sp_m1;
    logic           sp_full;
    logic           b_in_mem;
    logic           reg_ok;
    logic [RW-1:0]  reg_idx;
    logic [2:0]     raise;
    logic [2:0]     ex_raise;
    logic [1:0]     ex_cnt;
    logic [31:0]    ex_p0;
    logic [31:0]    ex_p1;
    logic           ex_pc_ld;
    logic           ex_cmp_ld;
    logic           ex_cmp_val;
    logic           ex_mwr;
    logic           ex_rwr;
    logic           ex_print;
    logic           ex_pic;
    logic           ex_iused;
    logic           ex_div;
    logic [32:0]    div_trial;
    logic [31:0]    rem_sh;
    logic [31:0]    div_rem_n;
    logic [31:0]    div_quo_n;
    logic [16:0]    pc_ext;

    function automatic logic [PW-1:0] wr_index(input logic [9:0] a);
        logic [16:0] t;
        t = 17'(a);
        for (int i = 0; i < 4; i++) begin
            if (t >= 17'(MEM_BYTES)) t = t - 17'(MEM_BYTES);
        end
        return t[PW-1:0];
    endfunction

    function automatic logic [31:0] rotl(input logic [31:0] a, input logic [4:0] n);
        logic [63:0] t;
        t = {a, a} << n;
        return t[63:32];
    endfunction

    assign pc_inc   = (r_pc == PW'(MEM_BYTES - 1)) ? '0 : r_pc + 1'b1;
    assign sp_m1    = r_sp - 1'b1;
    assign sp_full  = (r_sp >= SPW'(STACK_DEPTH));
    assign b_in_mem = (r_b < 32'(MEM_BYTES));
    assign reg_ok   = ({1'b0, r_opnd} < 9'(NUM_REGS));
    assign reg_idx  = RW'(r_opnd);
    assign pc_ext   = 17'(r_pc);

    // restoring divider, one quotient bit per step
    assign rem_sh    = {r_rem[30:0], r_quo[31]};
    assign div_trial = {1'b0, rem_sh} - {1'b0, r_dvs};
    assign div_rem_n = div_trial[32] ? rem_sh : div_trial[31:0];
    assign div_quo_n = {r_quo[30:0], ~div_trial[32]};

    always_comb begin
        ex_raise   = ERR_NONE;
        ex_cnt     = 2'd0;
        ex_p0      = r_b;
        ex_p1      = r_a;
        ex_pc_ld   = 1'b0;
        ex_cmp_ld  = 1'b0;
        ex_cmp_val = 1'b0;
        ex_mwr     = 1'b0;
        ex_rwr     = 1'b0;
        ex_print   = 1'b0;
        ex_pic     = 1'b0;
        ex_iused   = 1'b0;
        ex_div     = 1'b0;
        case (r_op)
            OP_HALT: ex_raise = ERR_HALT;
            OP_PUSH: begin
                ex_cnt = 2'd1;
                ex_p0  = {24'd0, r_opnd};
            end
            OP_POP: ex_cnt = 2'd0;
            OP_ADD: begin ex_cnt = 2'd1; ex_p0 = r_a + r_b; end
            OP_SUB: begin ex_cnt = 2'd1; ex_p0 = r_a - r_b; end
            OP_MUL: begin ex_cnt = 2'd1; ex_p0 = r_a * r_b; end
            OP_DIV: begin
                if (r_b == '0) ex_raise = ERR_DIVZ;
                else ex_div = 1'b1;
            end
            OP_AND: begin ex_cnt = 2'd1; ex_p0 = r_a & r_b; end
            OP_OR:  begin ex_cnt = 2'd1; ex_p0 = r_a | r_b; end
            OP_XOR: begin ex_cnt = 2'd1; ex_p0 = r_a ^ r_b; end
            OP_NOT: begin ex_cnt = 2'd1; ex_p0 = ~r_b; end
            OP_JMP: ex_pc_ld = 1'b1;
            OP_JZ:  ex_pc_ld = !r_cmp;
            OP_JNZ: ex_pc_ld = r_cmp;
            OP_EQ:  begin ex_cmp_ld = 1'b1; ex_cmp_val = (r_a == r_b); end
            OP_NEQ: begin ex_cmp_ld = 1'b1; ex_cmp_val = (r_a != r_b); end
            OP_GT:  begin ex_cmp_ld = 1'b1; ex_cmp_val = ($signed(r_a) > $signed(r_b)); end
            OP_LT:  begin ex_cmp_ld = 1'b1; ex_cmp_val = ($signed(r_a) < $signed(r_b)); end
            OP_LDB: begin
                if (b_in_mem) begin
                    ex_cnt = 2'd1;
                    ex_p0  = {24'd0, r_mem_q};
                end else begin
                    ex_raise = ERR_MEM;
                end
            end
            OP_STB: begin
                if (b_in_mem) ex_mwr = 1'b1;
                else ex_raise = ERR_MEM;
            end
            OP_LDR: begin
                if (reg_ok) begin
                    ex_cnt = 2'd1;
                    ex_p0  = r_reg_vq ? r_reg_q : '0;
                end else begin
                    ex_raise = ERR_REG;
                end
            end
            OP_STR: begin
                if (reg_ok) ex_rwr = 1'b1;
                else ex_raise = ERR_REG;
            end
            OP_PRD: ex_print = 1'b1;
            OP_PRC: begin ex_print = 1'b1; ex_pic = 1'b1; end
            OP_IN: begin
                ex_cnt   = 2'd1;
                ex_p0    = {{23{r_ichr[8]}}, r_ichr};
                ex_iused = 1'b1;
            end
            OP_ROL: begin ex_cnt = 2'd1; ex_p0 = rotl(r_a, r_b[4:0]); end
            OP_ROR: begin ex_cnt = 2'd1; ex_p0 = rotl(r_a, 5'(5'd0 - r_b[4:0])); end
            OP_SWAP: ex_cnt = 2'd2;
            OP_DUP: begin
                ex_cnt = 2'd2;
                ex_p1  = r_b;
            end
            default: ex_raise = ERR_BADOP;
        endcase
    end

    // at most one error source is active in any cycle
    always_comb begin
        raise = ERR_NONE;
        if (i_cmd.pop_req && (r_sp == '0)) raise = ERR_UNFL;
        if (i_cmd.push && sp_full) raise = ERR_OVFL;
        if (i_cmd.exec) raise = ex_raise;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc       <= '0;
            r_sp       <= '0;
            r_run      <= 1'b1;
            r_cmp      <= 1'b0;
            r_reg_vld  <= '0;
            r_clr_addr <= '0;
            r_err      <= ERR_NONE;
            r_push_cnt <= 2'd0;
            r_div_busy <= 1'b0;
            r_div_cnt  <= '0;
            r_o_valid  <= 1'b0;
        end else begin
            if (i_cmd.accept) r_err <= ERR_NONE;
            if (raise != ERR_NONE) begin
                if (r_err == ERR_NONE) r_err <= raise;
                r_run <= 1'b0;
            end
            if (i_cmd.init) begin
                r_pc       <= '0;
                r_sp       <= '0;
                r_run      <= 1'b1;
                r_cmp      <= 1'b0;
                r_reg_vld  <= '0;
                r_clr_addr <= '0;
            end
            if (i_cmd.clr_step) r_clr_addr <= r_clr_addr + 1'b1;
            if (i_cmd.fetch) r_pc <= pc_inc;
            if (i_cmd.pop_req && (r_sp != '0)) r_sp <= sp_m1;
            if (i_cmd.exec) begin
                r_push_cnt <= ex_cnt;
                if (ex_pc_ld) r_pc <= PW'(r_opnd);
                if (ex_cmp_ld) r_cmp <= ex_cmp_val;
                if (ex_rwr) r_reg_vld[reg_idx] <= 1'b1;
                if (ex_div) begin
                    r_div_busy <= 1'b1;
                    r_div_cnt  <= '0;
                end
            end
            if (i_cmd.div_step) begin
                r_div_cnt <= r_div_cnt + 1'b1;
                if (r_div_cnt == 5'd31) begin
                    r_div_busy <= 1'b0;
                    r_push_cnt <= 2'd1;
                end
            end
            if (i_cmd.push) begin
                r_push_cnt <= r_push_cnt - 1'b1;
                if (!sp_full) r_sp <= r_sp + 1'b1;
            end
            if (i_cmd.out_load) r_o_valid <= 1'b1;
            else if (i_ready) r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_func  <= i_func;
            r_addr  <= i_address;
            r_data  <= i_data_byte;
            r_ichr  <= i_input_char;
            r_pv    <= 1'b0;
            r_pic   <= 1'b0;
            r_pval  <= '0;
            r_iused <= 1'b0;
        end
        if (i_cmd.latch_op) r_op <= r_mem_q;
        if (i_cmd.latch_opnd) r_opnd <= r_mem_q;
        if (i_cmd.pop_req) r_pop_zero <= (r_sp == '0);
        if (i_cmd.pop_cap) begin
            if (i_cmd.pop_to_a) r_a <= r_pop_zero ? '0 : r_stk_q;
            else r_b <= r_pop_zero ? '0 : r_stk_q;
        end
        if (i_cmd.exec) begin
            r_push0 <= ex_p0;
            r_push1 <= ex_p1;
            if (ex_print) begin
                r_pv   <= 1'b1;
                r_pic  <= ex_pic;
                r_pval <= r_b;
            end
            if (ex_iused) r_iused <= 1'b1;
            if (ex_div) begin
                r_dvs     <= r_b[31] ? 32'(-r_b) : r_b;
                r_quo     <= r_a[31] ? 32'(-r_a) : r_a;
                r_rem     <= '0;
                r_div_neg <= r_a[31] ^ r_b[31];
            end
        end
        if (i_cmd.div_step) begin
            r_rem <= div_rem_n;
            r_quo <= div_quo_n;
            if (r_div_cnt == 5'd31) r_push0 <= r_div_neg ? 32'(-div_quo_n) : div_quo_n;
        end
        if (i_cmd.push) r_push0 <= r_push1;
        if (i_cmd.out_load) begin
            r_o_running <= r_run;
            r_o_pc      <= pc_ext[9:0];
            r_o_pv      <= r_pv;
            r_o_pic     <= r_pic;
            r_o_pval    <= r_pval;
            r_o_iused   <= r_iused;
            r_o_err     <= r_err;
        end
    end

    // program memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_step) begin
            r_mem[r_clr_addr] <= 8'd0;
        end else if (i_cmd.hwr) begin
            r_mem[wr_index(r_addr)] <= r_data;
        end else if (i_cmd.exec && ex_mwr) begin
            r_mem[r_b[PW-1:0]] <= r_a[7:0];
        end
        if (i_cmd.fetch) begin
            r_mem_q <= r_mem[r_pc];
        end else if (i_cmd.mem_rd && b_in_mem) begin
            r_mem_q <= r_mem[r_b[PW-1:0]];
        end
    end

    // value stack
    always_ff @(posedge i_clk) begin
        if (i_cmd.push && !sp_full) r_stk[r_sp[SW-1:0]] <= r_push0;
        if (i_cmd.pop_req && (r_sp != '0)) r_stk_q <= r_stk[sp_m1[SW-1:0]];
    end

    // general registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && ex_rwr) r_regs[reg_idx] <= r_b;
        if (i_cmd.reg_rd && reg_ok) begin
            r_reg_q  <= r_regs[reg_idx];
            r_reg_vq <= r_reg_vld[reg_idx];
        end
    end

    always_comb begin
        o_sts           = '0;
        o_sts.func      = r_func;
        o_sts.run       = r_run;
        o_sts.opcode    = r_op;
        o_sts.div_busy  = r_div_busy;
        o_sts.push_pend = (r_push_cnt != 2'd0);
        o_sts.clr_last  = (r_clr_addr == PW'(MEM_BYTES - 1));
        o_sts.out_free  = !r_o_valid || i_ready;
    end

    assign o_valid         = r_o_valid;
    assign o_running       = r_o_running;
    assign o_next_pc       = r_o_pc;
    assign o_print_valid   = r_o_pv;
    assign o_print_is_char = r_o_pic;
    assign o_print_value   = r_o_pval;
    assign o_input_used    = r_o_iused;
    assign o_error_code    = r_o_err;

endmodule

FILE: design/sbm_checker.sv
module sbm_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic [1:0]  i_func,
    input logic [9:0]  i_address,
    input logic [7:0]  i_data_byte,
    input logic [8:0]  i_input_char,
    input logic        o_valid,
    input logic        i_ready,
    input logic        o_running,
    input logic [9:0]  o_next_pc,
    input logic        o_print_valid,
    input logic        o_print_is_char,
    input logic [31:0] o_print_value,
    input logic        o_input_used,
    input logic [2:0]  o_error_code
);

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_ready |=> i_valid && $stable(i_func) && $stable(i_address)
                                && $stable(i_data_byte) && $stable(i_input_char))
        else $error("request changed while waiting");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_next_pc) && $stable(o_error_code)
                                && $stable(o_print_value))
        else $error("result changed while stalled");

    a_err_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_error_code != 3'd0) |-> !o_running)
        else $error("error reported while still running");

    a_char_print: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_print_is_char |-> o_print_valid)
        else $error("character print without print");

    a_one_effect: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_input_used |-> !o_print_valid)
        else $error("input and print in one instruction");

endmodule

bind stack_bytecode_machine_top sbm_checker u_chk (.*);
